/* rtl/ssp_pkg.sv */
package ssp_pkg;

	localparam logic [1:0] MODE_STOP   = 2'd0;
	localparam logic [1:0] MODE_LINE   = 2'd1;
	localparam logic [1:0] MODE_ANGLE  = 2'd2;
	localparam logic [1:0] MODE_MANUAL = 2'd3;

	localparam logic [2:0] CFG_LINE_P  = 3'd0;
	localparam logic [2:0] CFG_LINE_I  = 3'd1;
	localparam logic [2:0] CFG_LINE_D  = 3'd2;
	localparam logic [2:0] CFG_ANGLE_P = 3'd3;
	localparam logic [2:0] CFG_ANGLE_I = 3'd4;
	localparam logic [2:0] CFG_ANGLE_D = 3'd5;

	localparam int GAIN_W = 15;
	localparam int IN_W   = 80;
	localparam int OUT_W  = 32;

	// P gain ramps from kp/2 to kp over this error span
	localparam logic [15:0] LINE_SPAN = 16'd196;

	// x / 196 == ((x >> 2) * LINE_RECIP) >> LINE_RECIP_SH, exact for x below 2^22
	localparam logic [21:0] LINE_RECIP    = 22'd2739138;
	localparam int          LINE_RECIP_SH = 27;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SET,
		OP_L1,
		OP_L2,
		OP_L3,
		OP_L4,
		OP_L5,
		OP_L_KPE,
		OP_L_ACC,
		OP_A_MUL,
		OP_A_DIV,
		OP_A_TGT,
		OP_A_ERR,
		OP_A_I,
		OP_A_D,
		OP_A_ACC_I,
		OP_A_ACC_D,
		OP_OUT
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] mode;
		logic       ramp_done;
		logic       div_busy;
	} stat_t;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767)
			return 16'sh7fff;
		else if (v < -32'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

/* rtl/ssp_div.sv */
module ssp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [31:0] quot
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [31:0] quo_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

/* rtl/ssp_dp.sv */
module ssp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssp_pkg::cmd_t                 cmd,
	output ssp_pkg::stat_t                stat,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [ssp_pkg::GAIN_W-1:0]    cfg_data,
	input  logic                          kind,
	input  logic [ssp_pkg::IN_W-1:0]      in_data,
	output logic [ssp_pkg::OUT_W-1:0]     out_data
);
	import ssp_pkg::*;

	logic [GAIN_W-1:0] lgp_q, lgi_q, lgd_q, agp_q, agi_q, agd_q;

	logic               kind_q;
	logic signed [10:0] lerr_q;
	logic signed [11:0] steer_q;
	logic [1:0]         mode_in_q;
	logic signed [15:0] sp_q;
	logic [15:0]        rms_q;
	logic signed [15:0] rk_q;

	logic [1:0]         mode_q;
	logic signed [15:0] offset_q;
	logic signed [10:0] li_q;
	logic signed [16:0] prev_le_q;
	logic signed [15:0] goal_q;
	logic [15:0]        ramp_q;
	logic signed [15:0] rkst_q;
	logic [15:0]        elapsed_q;
	logic signed [11:0] start_q;
	logic signed [14:0] ai_q;
	logic signed [11:0] prev_ang_q;
	logic signed [15:0] manual_q;

	logic signed [17:0] err_q;
	logic signed [17:0] diff_q;
	logic [13:0]        half_q;
	logic               big_q;
	logic [14:0]        kq_q;
	logic signed [17:0] ma_q, mb_q;
	logic signed [35:0] prod_q;
	logic signed [31:0] acc_q;
	logic signed [16:0] tgt_q;
	logic               neg_q;
	logic signed [15:0] pwm_q;
	logic signed [15:0] tout_q;

	logic               div_start;
	logic [31:0]        div_dividend;
	logic [15:0]        div_divisor;
	logic               div_busy;
	logic [31:0]        div_quot;

	logic signed [17:0] l_err, l_diff, l_mag, a_err, a_tgt, q_s;
	logic signed [18:0] l_isum, a_isum;
	logic [14:0]        kmh;
	logic [41:0]        kq_prod;
	logic [15:0]        kpe_sum;
	logic [14:0]        kpe;
	logic [35:0]        prod_abs;
	logic               ramp_done;

	function automatic logic signed [31:0] trunc1024(input logic signed [35:0] p);
		logic signed [35:0] t;
		t = (p < 0) ? (p + 36'sd1023) >>> 10 : p >>> 10;
		return t[31:0];
	endfunction

	ssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	assign ramp_done = (ramp_q == 16'd0) || (elapsed_q >= ramp_q);

	always_comb begin
		l_err   = 18'(offset_q) - 18'(lerr_q);
		l_diff  = l_err - 18'(prev_le_q);
		l_mag   = (l_err < 0) ? -l_err : l_err;
		l_isum  = 19'(li_q) + 19'(l_err);
		kmh     = lgp_q - {1'b0, lgp_q[14:1]};
		// |err| * (kp - kp/2) / 196, only needed below the span
		kq_prod = {22'd0, prod_q[21:2]} * {20'd0, LINE_RECIP};
		kpe_sum = {2'd0, half_q} + {1'b0, kq_q};
		kpe     = (big_q || kpe_sum > {1'b0, lgp_q}) ? lgp_q : kpe_sum[14:0];
		q_s     = {1'b0, div_quot[16:0]};
		a_tgt   = 18'(start_q) + (neg_q ? -q_s : q_s);
		a_err   = 18'(steer_q) - 18'(tgt_q);
		a_isum  = 19'(ai_q) + 19'(a_err);
		prod_abs = (prod_q < 0) ? 36'(-prod_q) : 36'(prod_q);
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = prod_abs[31:0];
		div_divisor  = ramp_q;
		case (cmd.op)
			OP_A_DIV: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lgp_q <= '0;
			lgi_q <= '0;
			lgd_q <= '0;
			agp_q <= '0;
			agi_q <= '0;
			agd_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_P:  lgp_q <= cfg_data;
				CFG_LINE_I:  lgi_q <= cfg_data;
				CFG_LINE_D:  lgd_q <= cfg_data;
				CFG_ANGLE_P: agp_q <= cfg_data;
				CFG_ANGLE_I: agi_q <= cfg_data;
				CFG_ANGLE_D: agd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			lerr_q    <= in_data[10:0];
			steer_q   <= in_data[22:11];
			mode_in_q <= in_data[24:23];
			sp_q      <= in_data[40:25];
			rms_q     <= in_data[56:41];
			rk_q      <= in_data[72:57];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_STOP;
			offset_q   <= '0;
			li_q       <= '0;
			prev_le_q  <= '0;
			goal_q     <= '0;
			ramp_q     <= '0;
			rkst_q     <= '0;
			elapsed_q  <= '0;
			start_q    <= '0;
			ai_q       <= '0;
			prev_ang_q <= '0;
			manual_q   <= '0;
		end else begin
			case (cmd.op)
				OP_SET: begin
					mode_q <= mode_in_q;
					if (mode_in_q == MODE_LINE) begin
						if (mode_q != MODE_LINE || sp_q != offset_q) begin
							li_q      <= '0;
							prev_le_q <= 17'(sp_q) - 17'(lerr_q);
						end
						offset_q <= sp_q;
					end else if (mode_in_q == MODE_ANGLE) begin
						if (mode_q != MODE_ANGLE || sp_q != goal_q || rms_q != ramp_q
								|| rk_q != rkst_q) begin
							goal_q     <= sp_q;
							ramp_q     <= rms_q;
							rkst_q     <= rk_q;
							elapsed_q  <= '0;
							start_q    <= steer_q;
							ai_q       <= '0;
							prev_ang_q <= steer_q;
						end
					end else if (mode_in_q == MODE_MANUAL) begin
						manual_q <= sp_q;
					end
				end
				OP_L1: begin
					prev_le_q <= l_err[16:0];
					if (l_isum > 19'sd1023)
						li_q <= 11'sd1023;
					else if (l_isum < -19'sd1024)
						li_q <= -11'sd1024;
					else
						li_q <= l_isum[10:0];
				end
				OP_A_ERR: begin
					if (a_isum > 19'sd8192)
						ai_q <= 15'sd8192;
					else if (a_isum < -19'sd8192)
						ai_q <= -15'sd8192;
					else
						ai_q <= a_isum[14:0];
				end
				OP_A_D: prev_ang_q <= steer_q;
				OP_OUT: begin
					if (elapsed_q != 16'hffff)
						elapsed_q <= elapsed_q + 16'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 36'(ma_q) * 36'(mb_q);
		case (cmd.op) inside
			OP_L1: begin
				err_q  <= l_err;
				diff_q <= l_diff;
				half_q <= lgp_q[14:1];
				big_q  <= (l_mag >= $signed({2'd0, LINE_SPAN}));
				ma_q   <= l_mag;
				mb_q   <= {3'd0, kmh};
				acc_q  <= '0;
			end
			OP_L2: begin
				ma_q <= {3'd0, lgi_q};
				mb_q <= 18'(li_q);
			end
			OP_L3: begin
				kq_q <= kq_prod[LINE_RECIP_SH +: 15];
				ma_q <= {3'd0, lgd_q};
				mb_q <= diff_q;
			end
			OP_L4, OP_L5, OP_L_ACC: acc_q <= acc_q + trunc1024(prod_q);
			OP_L_KPE: begin
				ma_q <= {3'd0, kpe};
				mb_q <= err_q;
			end
			OP_A_MUL: begin
				ma_q <= 18'(goal_q) - 18'(start_q);
				mb_q <= {2'd0, elapsed_q};
			end
			OP_A_DIV: neg_q <= (prod_q < 0);
			OP_A_TGT: tgt_q <= ramp_done ? 17'(goal_q) : a_tgt[16:0];
			OP_A_ERR: begin
				err_q <= a_err;
				ma_q  <= {3'd0, agp_q};
				mb_q  <= a_err;
				acc_q <= '0;
			end
			OP_A_I: begin
				ma_q <= {3'd0, agi_q};
				mb_q <= 18'(ai_q);
			end
			OP_A_D: begin
				acc_q <= acc_q + 32'(prod_q >>> 5);
				ma_q  <= {3'd0, agd_q};
				mb_q  <= 18'(steer_q) - 18'(prev_ang_q);
			end
			OP_A_ACC_I: acc_q <= acc_q + 32'(prod_q >>> 12);
			OP_A_ACC_D: acc_q <= acc_q + 32'(prod_q >>> 8);
			OP_OUT: begin
				case (mode_q) inside
					MODE_LINE, MODE_ANGLE: pwm_q <= sat16(acc_q);
					MODE_MANUAL:           pwm_q <= manual_q;
					default:               pwm_q <= '0;
				endcase
				tout_q <= (mode_q == MODE_ANGLE) ? sat16(32'(tgt_q)) : 16'sd0;
			end
			default: ;
		endcase
	end

	assign stat.kind      = kind_q;
	assign stat.mode      = mode_q;
	assign stat.ramp_done = ramp_done;
	assign stat.div_busy  = div_busy;
	assign out_data       = {tout_q, pwm_q};

endmodule

/* rtl/ssp_ctrl.sv */
module ssp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output ssp_pkg::cmd_t  cmd,
	input  ssp_pkg::stat_t stat
);
	import ssp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_SET,
		S_L1, S_L2, S_L3, S_L4, S_L5, S_LW, S_L7, S_L8,
		S_A1, S_A2, S_A3, S_AW, S_A5, S_A6, S_A7, S_A8, S_A9,
		S_OUT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   mvalid_q;
	logic   slot_free;

	assign slot_free = !mvalid_q || m_tready;

	always_comb begin
		cmd.load = s_tvalid && ready_q;
		unique case (state_q)
			S_SET:  cmd.op = OP_SET;
			S_L1:   cmd.op = OP_L1;
			S_L2:   cmd.op = OP_L2;
			S_L3:   cmd.op = OP_L3;
			S_L4:   cmd.op = OP_L4;
			S_L5:   cmd.op = OP_L5;
			S_LW:   cmd.op = stat.div_busy ? OP_NONE : OP_L_KPE;
			S_L8:   cmd.op = OP_L_ACC;
			S_A1:   cmd.op = OP_A_MUL;
			S_A3:   cmd.op = OP_A_DIV;
			S_AW:   cmd.op = stat.div_busy ? OP_NONE : OP_A_TGT;
			S_A5:   cmd.op = OP_A_ERR;
			S_A6:   cmd.op = OP_A_I;
			S_A7:   cmd.op = OP_A_D;
			S_A8:   cmd.op = OP_A_ACC_I;
			S_A9:   cmd.op = OP_A_ACC_D;
			S_OUT:  cmd.op = slot_free ? OP_OUT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ready_q  <= 1'b1;
			mvalid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_OUT)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) begin
					ready_q <= 1'b0;
					state_q <= S_DISP;
				end
				S_DISP: begin
					if (stat.kind)
						state_q <= S_SET;
					else if (stat.mode == MODE_LINE)
						state_q <= S_L1;
					else if (stat.mode == MODE_ANGLE)
						state_q <= stat.ramp_done ? S_AW : S_A1;
					else
						state_q <= S_OUT;
				end
				S_SET: begin
					ready_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_L1: state_q <= S_L2;
				S_L2: state_q <= S_L3;
				S_L3: state_q <= S_L4;
				S_L4: state_q <= S_L5;
				S_L5: state_q <= S_LW;
				S_LW: if (!stat.div_busy) state_q <= S_L7;
				S_L7: state_q <= S_L8;
				S_L8: state_q <= S_OUT;
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_A3;
				S_A3: state_q <= S_AW;
				S_AW: if (!stat.div_busy) state_q <= S_A5;
				S_A5: state_q <= S_A6;
				S_A6: state_q <= S_A7;
				S_A7: state_q <= S_A8;
				S_A8: state_q <= S_A9;
				S_A9: state_q <= S_OUT;
				S_OUT: if (slot_free) begin
					ready_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = ready_q;
	assign m_tvalid = mvalid_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> state_q == S_IDLE)
		else $error("ready outside idle");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> slot_free)
		else $error("result overwrites waiting beat");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q && !m_tready |=> mvalid_q)
		else $error("stalled result dropped");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LW && !stat.div_busy |=> state_q == S_L7)
		else $error("line step left divide wait wrongly");

endmodule

/* rtl/steering_servo_pid_modes.sv */
// Steering servo PID controller with stop, line trace, angle ramp and manual modes.
// Input stream: s_tuser is the kind (0 = 1 ms control tick, 1 = set mode);
// s_tdata carries the sensor values and mode parameters. A set-mode beat gives
// no result; every tick beat gives one output beat with pwm and target_angle.
// One item is handled at a time: s_tready is high only while idle.
// An angle tick skips the ramp divide once the ramp has ended; while the ramp
// runs, it waits on the 32-step divider that computes the ramp target.
// A tick's result beat and s_tready rise together.
// One 18x18 multiplier is shared by all terms; the line P gain scale uses a
// constant reciprocal multiply.
// The result sits in an output register; if m_tready is low the next item is
// still accepted and worked on, and it waits before its result stage until the
// held beat is taken. The user must write cfg_* gains while idle (unchecked).
// Reset clears gains, mode (stop), integrators, histories and the ramp timer.
module steering_servo_pid_modes (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [10:0] line_dev, [22:11] steer_pos, [24:23] mode, [40:25] setpoint,
	// [56:41] ramp_ms, [72:57] ramp_coef, [79:73] zero
	input  logic [ssp_pkg::IN_W-1:0]   s_tdata,
	// [0] kind
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [15:0] pwm, [31:16] target_angle
	output logic [ssp_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [ssp_pkg::GAIN_W-1:0] cfg_data
);
	import ssp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ssp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	ssp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.kind      (s_tuser),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule
